@@ hw/rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, off while reset is low
`define ORB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// condition in one cycle implies outcome in the next
`define ORB_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ hw/rtl/orb_pkg.sv @@
package orb_pkg;

    localparam int WORD_W  = 64;
    localparam int COUNT_W = 8;
    localparam int CAP_W   = 5;
    localparam int CMD_W   = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // command codes on the input channel
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LIST   = 2'd2;

    // operation codes inside the queue
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LIST   = 2'd2;

    typedef logic [1:0] t_op;

    typedef struct packed {
        t_op                op;
        logic [WORD_W-1:0]  word;
        logic [COUNT_W-1:0] count;
    } t_op_item;

endpackage

@@ hw/rtl/orb_in_if.sv @@
interface orb_in_if;
    import orb_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [WORD_W-1:0]  entry_word;
    logic [COUNT_W-1:0] remove_count;

    modport source (output valid, output cmd, output entry_word, output remove_count,
                    input ready);
    modport sink   (input valid, input cmd, input entry_word, input remove_count,
                    output ready);
endinterface

@@ hw/rtl/orb_out_if.sv @@
interface orb_out_if;
    import orb_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] entry_word_res;
    logic              last_flag;

    modport source (output valid, output entry_word_res, output last_flag, input ready);
    modport sink   (input valid, input entry_word_res, input last_flag, output ready);
endinterface

@@ hw/rtl/orb_front.sv @@
`include "assert_macros.svh"

module orb_front
    import orb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    orb_in_if.sink   i_in,
    output t_op_item o_item,
    output logic     o_q_valid,
    input  logic     i_pop
);

    t_op_item   r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    t_op  cls_op;
    logic cls_ok;
    logic accept;
    logic push;
    logic pop;

    always_comb begin
        cls_op = OP_APPEND;
        cls_ok = 1'b1;
        case (i_in.cmd)
            CMD_APPEND: cls_op = OP_APPEND;
            CMD_REMOVE: cls_op = OP_REMOVE;
            CMD_LIST:   cls_op = OP_LIST;
            default:    cls_ok = 1'b0;
        endcase
    end

    assign i_in.ready = (r_count != 2'd2);
    assign accept     = i_in.valid && i_in.ready;
    // unused codes are taken and dropped here
    assign push       = accept && cls_ok;
    assign pop        = i_pop && (r_count != 2'd0);
    assign o_q_valid  = (r_count != 2'd0);
    assign o_item     = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= '{op: cls_op, word: i_in.entry_word, count: i_in.remove_count};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    `ORB_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= 2'd2, "queue count out of range")
    `ORB_ASSERT_NEXT(a_drop_unused, i_clk, i_rst_n, accept && !cls_ok && !pop,
        $stable(r_count), "unused command entered the queue")
    `ORB_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, push && !pop,
        r_count == $past(r_count) + 2'd1, "push did not grow the queue")

endmodule

@@ hw/rtl/orb_back.sv @@
`include "assert_macros.svh"

module orb_back
    import orb_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int ENTRY_WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    input  t_op_item         i_item,
    input  logic             i_q_valid,
    output logic             o_pop,
    orb_out_if.source        o_out
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);
    localparam int SW = FW + 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LIST = 1'b1;

    logic [ENTRY_WIDTH-1:0] mem [DEPTH];

    logic                   r_state;
    logic [IW-1:0]          r_head;
    logic [FW-1:0]          r_fill;
    logic [CAP_W-1:0]       r_cap;
    logic [FW-1:0]          r_idx;
    logic                   r_out_valid;
    logic [ENTRY_WIDTH-1:0] r_mem_q;
    logic                   r_last;

    logic [FW-1:0] cap_eff;
    logic [FW-1:0] cfg_eff;
    logic          rd_en;
    logic          rd_last;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic          rm_ok;

    function automatic logic [FW-1:0] eff_cap(input logic [CAP_W-1:0] c);
        logic [FW-1:0] e;
        if (c == '0) begin
            e = FW'(1);
        end else if (int'(c) > DEPTH) begin
            e = FW'(DEPTH);
        end else begin
            e = FW'(c);
        end
        return e;
    endfunction

    // head + n stays below twice the depth, so one subtract wraps it
    function automatic logic [IW-1:0] wrap(input logic [IW-1:0] h, input logic [FW-1:0] n);
        logic [SW-1:0] s;
        s = SW'(h) + SW'(n);
        if (s >= SW'(DEPTH)) begin
            s = s - SW'(DEPTH);
        end
        return IW'(s);
    endfunction

    assign cap_eff = eff_cap(r_cap);
    assign cfg_eff = eff_cap(i_cfg_wdata);
    assign o_pop   = (r_state == S_IDLE) && i_q_valid;
    assign rm_ok   = i_item.count <= COUNT_W'(r_fill);
    assign wr_en   = o_pop && (i_item.op == OP_APPEND);
    assign wr_addr = wrap(r_head, r_fill);
    assign rd_en   = (r_state == S_LIST) && (!r_out_valid || o_out.ready);
    assign rd_addr = wrap(r_head, r_idx);
    assign rd_last = (r_idx == r_fill - FW'(1));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_item.word[ENTRY_WIDTH-1:0];
        end
        // read register doubles as the output register, held while stalled
        if (rd_en) begin
            r_mem_q <= mem[rd_addr];
            r_last  <= rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_fill      <= '0;
            r_cap       <= CAP_RESET;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
                if (r_fill > cfg_eff) begin
                    r_head <= wrap(r_head, r_fill - cfg_eff);
                    r_fill <= cfg_eff;
                end
            end else if (o_pop) begin
                case (i_item.op)
                    OP_APPEND: begin
                        if (r_fill >= cap_eff) begin
                            r_head <= wrap(r_head, FW'(1));
                        end else begin
                            r_fill <= r_fill + FW'(1);
                        end
                    end
                    OP_REMOVE: begin
                        if (rm_ok) begin
                            r_head <= wrap(r_head, FW'(i_item.count));
                            r_fill <= r_fill - FW'(i_item.count);
                        end
                    end
                    OP_LIST: begin
                        if (r_fill != '0) begin
                            r_state <= S_LIST;
                            r_idx   <= '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if (rd_en) begin
                r_idx <= r_idx + FW'(1);
                if (rd_last) begin
                    r_state <= S_IDLE;
                end
            end

            if (rd_en) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.entry_word_res = WORD_W'(r_mem_q);
    assign o_out.last_flag      = r_last;

    `ORB_ASSERT(a_fill_bound, i_clk, i_rst_n, r_fill <= cap_eff, "fill above capacity")
    `ORB_ASSERT(a_list_index, i_clk, i_rst_n, (r_state != S_LIST) || (r_idx < r_fill),
        "list index beyond fill")
    `ORB_ASSERT_NEXT(a_remove_ignored, i_clk, i_rst_n,
        o_pop && (i_item.op == OP_REMOVE) && !rm_ok && !i_cfg_we,
        $stable(r_fill) && $stable(r_head), "oversized remove changed state")

endmodule

@@ hw/rtl/overwriting_ring_buffer_core.sv @@
// Ring buffer that keeps the newest entries up to a programmable capacity.
// Input channel i_in: cmd append (stores entry_word, dropping the oldest
// entry when full), remove (drops remove_count oldest entries, ignored if
// larger than the fill) or list (replays all held entries, oldest first).
// Output channel o_out: one beat per held entry during a list, last_flag
// high on the final beat; an empty buffer lists nothing.
// Capacity register: i_cfg_we / i_cfg_wdata; the user must write it only while
// idle, which the block itself does not enforce; zero acts as one, values
// above DEPTH act as DEPTH, and lowering it drops the oldest entries down to
// the new capacity. An accepted command waits in the command queue and
// takes effect when the execute unit pops it; list beats go from the entry
// memory through the read register to o_out. No command is popped while a
// list runs; a list gives one beat per cycle unless o_out stalls, set by
// the single read port of the entry memory. A two-deep command queue lets
// input beats be taken while a list drains.
// Reset: buffer empty, capacity 16; entry memory is not cleared.
// A stall on o_out holds the current beat and pauses the list; the queue
// fills and then i_in.ready drops.
module overwriting_ring_buffer_core
    import orb_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int ENTRY_WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    orb_in_if.sink           i_in,
    orb_out_if.source        o_out
);

    t_op_item item;
    logic     q_valid;
    logic     pop;

    orb_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_item    (item),
        .o_q_valid (q_valid),
        .i_pop     (pop)
    );

    orb_back #(
        .DEPTH       (DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (item),
        .i_q_valid   (q_valid),
        .o_pop       (pop),
        .o_out       (o_out)
    );

endmodule
